// File: rtl/core/lalp_pkg.sv
// Package for the LED animation loader and player.
// Holds sizes, character codes and the hex-digit decode; no dependencies.
package lalp_pkg;
    localparam int FRAMES_DEF     = 35;
    localparam int LEDS_DEF       = 8;
    localparam int LINE_BYTES_DEF = 64;
    localparam int OUT_LEDS       = 8;
    localparam logic [15:0] DELAY_CEIL = 16'd60000;

    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_ERROR = 2'd2;

    localparam logic [7:0] CH_S  = 8'h53;
    localparam logic [7:0] CH_F  = 8'h46;
    localparam logic [7:0] CH_E  = 8'h45;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Decode one hex character; anything else reads as zero
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            v = c[3:0] + 4'd9;
        return v;
    endfunction
endpackage

// File: rtl/core/lalp_if.sv
// Valid/ready channel interfaces for the input and result transactions.
// Depends on nothing.
interface lalp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] rx_byte;
    modport source (output valid, cmd, rx_byte, input ready);
    modport sink   (input valid, cmd, rx_byte, output ready);
endinterface

interface lalp_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] led0_rgb;
    logic [23:0] led1_rgb;
    logic [23:0] led2_rgb;
    logic [23:0] led3_rgb;
    logic [23:0] led4_rgb;
    logic [23:0] led5_rgb;
    logic [23:0] led6_rgb;
    logic [23:0] led7_rgb;
    logic [5:0]  shown_frame;
    modport source (output valid, led0_rgb, led1_rgb, led2_rgb, led3_rgb, led4_rgb,
                    led5_rgb, led6_rgb, led7_rgb, shown_frame, input ready);
    modport sink   (input valid, led0_rgb, led1_rgb, led2_rgb, led3_rgb, led4_rgb,
                    led5_rgb, led6_rgb, led7_rgb, shown_frame, output ready);
endinterface

// File: rtl/core/lalp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module lalp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, then register the read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/core/led_animation_loader_player.sv
// LED animation loader and player top level: sequencer and memories.
// Depends on lalp_pkg, lalp_if and lalp_ram.
//
// Usage: s_in carries transactions of cmd (0 byte, 1 ms tick, 2 receive
// error) and rx_byte. m_out carries one transaction per shown frame: eight
// 24-bit colours and the frame index.
// Bytes are stored in a line RAM; CR/LF ends a line and the sequencer parses
// it by reading the line RAM one character per cycle. A plain byte, a receive
// error or a tick while the active bank is empty is handled in the idle state;
// a dropped line end passes through S_RD0 and S_DISP; a frame line then goes
// through S_PARSE; an 'S' line is parsed and then clears the loading bank one
// colour entry a cycle. A tick that shows nothing passes through S_TICKRD and
// S_TICKCK. A tick or an 'E' line that shows a frame reads LEDS colours into a
// staging row in S_SHOW, then S_PUSH loads it; the result becomes valid in
// the same cycle that s_in.ready rises again. One transaction
// is processed at a time; s_in.ready is low while a line is parsed or a
// frame is read out.
// After reset a clearing pass zeroes the colour and delay RAMs before the
// first input is accepted.
// A finished result sits in the output register; if the receiver stalls the
// block still accepts the next input, and waits only before loading a new
// result into an occupied output register.
module led_animation_loader_player
    import lalp_pkg::*;
#(
    parameter int FRAMES     = FRAMES_DEF,
    parameter int LEDS       = LEDS_DEF,
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lalp_in_if.sink    s_in,
    lalp_out_if.source m_out
);
    localparam int LW  = $clog2(LINE_BYTES);
    localparam int LCW = $clog2(LINE_BYTES + 1);
    localparam int CD  = 2 * FRAMES * LEDS;
    localparam int CW  = $clog2(CD);
    localparam int DD  = 2 * FRAMES;
    localparam int DW  = $clog2(DD);
    localparam int PW  = $clog2(FRAMES + 1);
    localparam int LDW = (LEDS > 1) ? $clog2(LEDS) : 1;
    localparam int OW  = $clog2(OUT_LEDS);
    localparam int FLEN = 5 + 6 * LEDS;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_RD0    = 10'b0000000100,
        S_DISP   = 10'b0000001000,
        S_PARSE  = 10'b0000010000,
        S_SCLR   = 10'b0000100000,
        S_TICKRD = 10'b0001000000,
        S_TICKCK = 10'b0010000000,
        S_SHOW   = 10'b0100000000,
        S_PUSH   = 10'b1000000000
    } t_state;

    t_state            r_state, n_state;
    logic [LCW-1:0]    r_len, n_len;
    logic [PW-1:0]     r_cnt [2];
    logic [PW-1:0]     r_pos [2];
    logic [PW-1:0]     n_cnt [2];
    logic [PW-1:0]     n_pos [2];
    logic              r_act, n_act;
    logic [15:0]       r_ms, n_ms;
    logic [7:0]        r_first, n_first;
    logic [LCW-1:0]    r_lidx, n_lidx;   // next line index to read
    logic [LCW-1:0]    r_pidx, n_pidx;   // index of char in rdata
    logic [23:0]       r_acc, n_acc;
    logic [2:0]        r_dig, n_dig;     // digit within a colour word
    logic [CW:0]       r_cc, n_cc;       // clear / show / LED counter
    logic              r_bank, n_bank;
    logic [PW-1:0]     r_fpos, n_fpos;
    logic              r_blank, n_blank;
    logic [23:0]       r_row [OUT_LEDS];
    logic [23:0]       n_row [OUT_LEDS];
    logic [23:0]       r_led [OUT_LEDS];
    logic [23:0]       n_led [OUT_LEDS];
    logic [5:0]        r_frm, n_frm;
    logic              r_ov, n_ov;

    logic              l_we;
    logic [LW-1:0]     l_wa, l_ra;
    logic [7:0]        l_wd, l_rd;
    logic              c_we;
    logic [CW-1:0]     c_wa, c_ra;
    logic [23:0]       c_wd, c_rd;
    logic              d_we;
    logic [DW-1:0]     d_wa, d_ra;
    logic [15:0]       d_wd, d_rd;

    lalp_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_line (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_wa), .i_wdata(l_wd),
        .i_raddr(l_ra), .o_rdata(l_rd));
    lalp_ram #(.WIDTH(24), .DEPTH(CD)) u_color (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_wa), .i_wdata(c_wd),
        .i_raddr(c_ra), .o_rdata(c_rd));
    lalp_ram #(.WIDTH(16), .DEPTH(DD)) u_delay (
        .i_clk(i_clk), .i_we(d_we), .i_waddr(d_wa), .i_wdata(d_wd),
        .i_raddr(d_ra), .o_rdata(d_rd));

    logic in_fire, out_fire, out_free;
    assign out_free = !r_ov || m_out.ready;
    assign s_in.ready = (r_state == S_IDLE);
    assign in_fire = s_in.valid && s_in.ready;
    assign out_fire = r_ov && m_out.ready;

    // Address helpers
    function automatic logic [CW-1:0] caddr(input logic b, input logic [PW-1:0] f,
                                            input logic [LDW-1:0] l);
        return CW'((32'(b) * FRAMES + 32'(f)) * LEDS + 32'(l));
    endfunction
    function automatic logic [DW-1:0] daddr(input logic b, input logic [PW-1:0] f);
        return DW'(32'(b) * FRAMES + 32'(f));
    endfunction

    logic [3:0] hv;
    logic [15:0] dclamp;
    logic [PW-1:0] nxt;
    assign hv = hex_val(l_rd);

    always_comb begin
        n_state = r_state; n_len = r_len; n_cnt = r_cnt; n_pos = r_pos;
        n_act = r_act; n_ms = r_ms; n_first = r_first; n_lidx = r_lidx;
        n_pidx = r_pidx; n_acc = r_acc; n_cc = r_cc; n_bank = r_bank;
        n_fpos = r_fpos; n_blank = r_blank; n_led = r_led; n_frm = r_frm;
        n_dig = r_dig; n_row = r_row;
        n_ov = out_fire ? 1'b0 : r_ov;
        l_we = 1'b0; l_wa = r_len[LW-1:0]; l_wd = s_in.rx_byte;
        l_ra = r_lidx[LW-1:0];
        c_we = 1'b0; c_wa = r_cc[CW-1:0]; c_wd = '0;
        c_ra = caddr(r_bank, r_fpos, r_cc[LDW-1:0]);
        d_we = 1'b0; d_wa = r_cc[DW-1:0]; d_wd = '0;
        d_ra = daddr(r_act, r_pos[r_act]);
        dclamp = '0; nxt = '0;
        case (r_state)
            // Zero both stores after reset
            S_CLEAR: begin
                c_we = 1'b1;
                d_we = (r_cc < (CW+1)'(DD));
                if (r_cc == (CW+1)'(CD - 1)) begin n_state = S_IDLE; n_cc = '0; end
                else n_cc = r_cc + 1'b1;
            end
            S_IDLE: begin
                if (in_fire) begin
                    case (s_in.cmd)
                        CMD_BYTE: begin
                            if (s_in.rx_byte == CH_CR || s_in.rx_byte == CH_LF) begin
                                if (r_len != '0) begin
                                    n_lidx = '0; n_state = S_RD0;
                                end
                            end else begin
                                l_we = 1'b1;
                                n_len = (r_len + 1'b1 >= LCW'(LINE_BYTES)) ? '0
                                                                         : r_len + 1'b1;
                            end
                        end
                        CMD_TICK: begin
                            n_ms = r_ms + 16'd1;
                            if (r_cnt[r_act] != '0 && r_pos[r_act] < PW'(FRAMES))
                                n_state = S_TICKRD;
                        end
                        CMD_ERROR: n_len = '0;
                        default: ;
                    endcase
                end
            end
            // Issue read of the first character
            S_RD0: begin
                l_ra = '0; n_lidx = LCW'(1); n_state = S_DISP;
            end
            S_DISP: begin
                n_first = l_rd; n_bank = !r_act; n_len = '0;
                n_acc = '0; n_pidx = LCW'(1);
                n_fpos = r_pos[!r_act];
                n_lidx = LCW'(2); l_ra = LW'(1);
                n_state = S_IDLE;
                if (l_rd == CH_S && r_len == LCW'(3)) n_state = S_PARSE;
                else if (l_rd == CH_F && r_len == LCW'(FLEN)
                         && r_pos[!r_act] < PW'(FRAMES)) n_state = S_PARSE;
                else if (l_rd == CH_E) begin
                    n_pos[!r_act] = '0; n_act = !r_act; n_ms = '0;
                    n_fpos = '0; n_blank = (r_cnt[!r_act] == '0);
                    n_cc = '0; n_state = S_SHOW;
                end
            end
            // Consume one character per cycle
            S_PARSE: begin
                n_acc = {r_acc[19:0], hv};
                n_pidx = r_pidx + 1'b1; n_lidx = r_lidx + 1'b1;
                if (r_first == CH_S) begin
                    if (r_pidx == LCW'(2)) begin
                        n_cnt[r_bank] = ({r_acc[3:0], hv} > 8'(FRAMES)) ? PW'(FRAMES)
                                        : PW'({r_acc[3:0], hv});
                        n_pos[r_bank] = '0; n_cc = '0; n_state = S_SCLR;
                    end
                end else begin
                    if (r_pidx == LCW'(4)) begin
                        dclamp = {r_acc[11:0], hv};
                        d_we = 1'b1; d_wa = daddr(r_bank, r_fpos);
                        d_wd = (dclamp > DELAY_CEIL) ? DELAY_CEIL : dclamp;
                        n_acc = '0; n_dig = '0; n_cc = '0;
                    end else if (r_pidx > LCW'(4)) begin
                        // Write a colour after its sixth digit, then step the LED
                        if (r_dig == 3'd5) begin
                            c_we = 1'b1; c_wa = caddr(r_bank, r_fpos, r_cc[LDW-1:0]);
                            c_wd = {r_acc[19:0], hv}; n_acc = '0; n_dig = '0;
                            n_cc = r_cc + 1'b1;
                            if (r_pidx == LCW'(FLEN - 1)) begin
                                n_pos[r_bank] = r_fpos + 1'b1; n_state = S_IDLE;
                            end
                        end else n_dig = r_dig + 3'd1;
                    end
                end
            end
            // Clear the loading bank, one colour entry a cycle
            S_SCLR: begin
                c_we = 1'b1;
                c_wa = CW'(32'(r_bank) * FRAMES * LEDS + 32'(r_cc));
                d_we = (r_cc < (CW+1)'(FRAMES)); d_wa = daddr(r_bank, PW'(r_cc));
                if (r_cc == (CW+1)'(FRAMES * LEDS - 1)) n_state = S_IDLE;
                else n_cc = r_cc + 1'b1;
            end
            S_TICKRD: begin
                d_ra = daddr(r_act, r_pos[r_act]); n_state = S_TICKCK;
            end
            S_TICKCK: begin
                n_state = S_IDLE;
                if (r_ms >= d_rd) begin
                    n_ms = '0;
                    nxt = (r_pos[r_act] + 1'b1 >= r_cnt[r_act]) ? '0 : r_pos[r_act] + 1'b1;
                    n_pos[r_act] = nxt; n_bank = r_act; n_fpos = nxt;
                    n_blank = 1'b0; n_cc = '0; n_state = S_SHOW;
                end
            end
            // Read LEDS colours, one per cycle, into the staging row
            S_SHOW: begin
                c_ra = caddr(r_bank, r_fpos, r_cc[LDW-1:0]);
                if (r_cc != '0) n_row[OW'(r_cc - 1'b1)] = r_blank ? 24'd0 : c_rd;
                if (r_cc == (CW+1)'(LEDS)) n_state = S_PUSH;
                else n_cc = r_cc + 1'b1;
            end
            // Hold the staged row until the output register is free
            S_PUSH: begin
                if (out_free) begin
                    for (int i = 0; i < OUT_LEDS; i++)
                        n_led[i] = (i < LEDS) ? r_row[i] : 24'd0;
                    n_frm = 6'(r_fpos); n_ov = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_len <= '0; r_cnt <= '{default: '0};
            r_pos <= '{default: '0}; r_act <= 1'b0; r_ms <= '0; r_cc <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_len <= n_len; r_cnt <= n_cnt; r_pos <= n_pos;
            r_act <= n_act; r_ms <= n_ms; r_cc <= n_cc; r_ov <= n_ov;
        end
        r_first <= n_first; r_lidx <= n_lidx; r_pidx <= n_pidx; r_acc <= n_acc;
        r_bank <= n_bank; r_fpos <= n_fpos; r_blank <= n_blank;
        r_frm <= n_frm; r_dig <= n_dig; r_row <= n_row; r_led <= n_led;
    end

    assign m_out.valid = r_ov;
    assign m_out.led0_rgb = r_led[0];
    assign m_out.led1_rgb = r_led[1];
    assign m_out.led2_rgb = r_led[2];
    assign m_out.led3_rgb = r_led[3];
    assign m_out.led4_rgb = r_led[4];
    assign m_out.led5_rgb = r_led[5];
    assign m_out.led6_rgb = r_led[6];
    assign m_out.led7_rgb = r_led[7];
    assign m_out.shown_frame = r_frm;

`ifndef SYNTH
    // No input is taken during the clearing pass
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_in.ready) else $error("input during clear");
    // A waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !m_out.ready) |=> (r_ov && $stable(r_frm) && $stable(m_out.led0_rgb)))
        else $error("result lost");
    // Shown positions stay within the store
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos[0] <= PW'(FRAMES)) && (r_pos[1] <= PW'(FRAMES))) else $error("pos range");
`endif
endmodule

// File: bench/lalp_checker.sv
// Checker for the LED animation loader and player: watches both channels,
// predicts every shown frame and compares it field by field.
// Depends on lalp_pkg and the channel interfaces in lalp_if.
module lalp_checker
    import lalp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    lalp_in_if   in_ch,
    lalp_out_if  out_ch,
    output int   o_fail_count,
    output int   o_pending
);
    localparam int FRAME_LINE_LEN = 5 + 6 * LEDS_DEF;

    typedef struct packed {
        logic [OUT_LEDS-1:0][23:0] rgb;
        logic [5:0]                frame;
    } t_frame_view;

    t_frame_view shown_q[$];

    // Own copy of the player state
    logic [7:0]  line_buf [LINE_BYTES_DEF];
    int          line_len;
    logic [23:0] colours [2][FRAMES_DEF][LEDS_DEF];
    logic [15:0] delays [2][FRAMES_DEF];
    int          frame_count [2];
    int          position [2];
    int          active;
    logic [15:0] ms_elapsed;

    function automatic logic [3:0] digit_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return 4'(c - "0");
        if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
        if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
        return 4'd0;
    endfunction

    function automatic logic [31:0] read_hex(input int start, input int digits);
        logic [31:0] v;
        v = 0;
        for (int i = 0; i < digits; i++)
            v = (v << 4) | digit_of(start + i < LINE_BYTES_DEF ? line_buf[start + i] : 8'd0);
        return v;
    endfunction

    // Queue the frame now shown in a bank
    task automatic show_frame(input int b);
        t_frame_view f;
        int p;
        p = position[b];
        f.rgb = '0;
        for (int i = 0; i < LEDS_DEF; i++)
            if (frame_count[b] != 0 && p < FRAMES_DEF) f.rgb[i] = colours[b][p][i];
        f.frame = 6'(p);
        shown_q.push_back(f);
    endtask

    task automatic finish_line();
        int loading;
        int p;
        logic [31:0] v;
        loading = active ^ 1;
        p = position[loading];
        case (line_buf[0])
            CH_S: if (line_len == 3) begin
                for (int k = 0; k < FRAMES_DEF; k++) begin
                    delays[loading][k] = '0;
                    for (int i = 0; i < LEDS_DEF; i++) colours[loading][k][i] = '0;
                end
                position[loading] = 0;
                v = read_hex(1, 2);
                frame_count[loading] = v > FRAMES_DEF ? FRAMES_DEF : int'(v);
            end
            CH_F: if (line_len == FRAME_LINE_LEN && p < FRAMES_DEF) begin
                v = read_hex(1, 4);
                delays[loading][p] = v > DELAY_CEIL ? DELAY_CEIL : v[15:0];
                for (int i = 0; i < LEDS_DEF; i++)
                    colours[loading][p][i] = read_hex(5 + 6 * i, 6);
                position[loading] = p + 1;
            end
            CH_E: begin
                position[loading] = 0;
                active = loading;
                show_frame(active);
                ms_elapsed = '0;
            end
            default: ;
        endcase
        line_len = 0;
    endtask

    task automatic take_tick();
        int b;
        b = active;
        ms_elapsed = ms_elapsed + 16'd1;
        if (frame_count[b] != 0 && position[b] < FRAMES_DEF
                && ms_elapsed >= delays[b][position[b]]) begin
            ms_elapsed = '0;
            position[b] = position[b] + 1 >= frame_count[b] ? 0 : position[b] + 1;
            show_frame(b);
        end
    endtask

    task automatic take_input(input logic [1:0] c, input logic [7:0] b);
        case (c)
            CMD_BYTE: begin
                if (b == CH_CR || b == CH_LF) begin
                    if (line_len < LINE_BYTES_DEF) line_buf[line_len] = '0;
                    if (line_len > 0) finish_line();
                end else begin
                    if (line_len < LINE_BYTES_DEF) line_buf[line_len] = b;
                    line_len++;
                    if (line_len >= LINE_BYTES_DEF) line_len = 0;
                end
            end
            CMD_TICK:  take_tick();
            CMD_ERROR: line_len = 0;
            default: ;
        endcase
    endtask

    task automatic check_result();
        t_frame_view want;
        logic [OUT_LEDS-1:0][23:0] got;
        got = {out_ch.led7_rgb, out_ch.led6_rgb, out_ch.led5_rgb, out_ch.led4_rgb,
               out_ch.led3_rgb, out_ch.led2_rgb, out_ch.led1_rgb, out_ch.led0_rgb};
        if (shown_q.size() == 0) begin
            $error("unexpected frame transaction, shown_frame %0d", out_ch.shown_frame);
            o_fail_count++;
            return;
        end
        want = shown_q.pop_front();
        for (int i = 0; i < OUT_LEDS; i++)
            if (got[i] !== want.rgb[i]) begin
                $error("led%0d_rgb expected %h actual %h", i, want.rgb[i], got[i]);
                o_fail_count++;
            end
        if (out_ch.shown_frame !== want.frame) begin
            $error("shown_frame expected %0d actual %0d", want.frame, out_ch.shown_frame);
            o_fail_count++;
        end
    endtask

    // Compare outgoing frames before predicting, then take the incoming transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_fail_count = 0;
            o_pending = 0;
            line_len = 0;
            for (int k = 0; k < FRAMES_DEF; k++)
                for (int j = 0; j < 2; j++) begin
                    delays[j][k] = '0;
                    for (int i = 0; i < LEDS_DEF; i++) colours[j][k][i] = '0;
                end
            frame_count = '{0, 0};
            position = '{0, 0};
            active = 0;
            ms_elapsed = '0;
        end else begin
            if (out_ch.valid && out_ch.ready) check_result();
            if (in_ch.valid && in_ch.ready) take_input(in_ch.cmd, in_ch.rx_byte);
            o_pending = shown_q.size();
        end
    end
endmodule

// File: bench/led_animation_loader_player_tb.sv
// Top of the bench for the LED animation loader and player: clock, reset,
// text and tick stimulus with random gaps, and the verdict.
// Depends on lalp_pkg, lalp_if, the block and lalp_checker.
module led_animation_loader_player_tb
    import lalp_pkg::*;
;

    logic i_clk;
    logic i_rst_n;
    logic calm;
    int   fail_count;
    int   pending;
    int   sent;

    lalp_in_if  in_ch ();
    lalp_out_if out_ch ();

    led_animation_loader_player dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (in_ch),
        .m_out   (out_ch)
    );

    lalp_checker frame_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stall the frame receiver at random unless in a calm stretch
    always @(posedge i_clk) begin
        out_ch.ready <= calm || ($urandom_range(99) >= 22);
    end

    // Hold one transaction until the block takes it, idling at random first
    task automatic push_item(input logic [1:0] c, input logic [7:0] b);
        while (!calm && $urandom_range(99) < 22) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.cmd     <= c;
        in_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    function automatic logic [7:0] line_end();
        return $urandom_range(1) ? CH_CR : CH_LF;
    endfunction

    // Hex digit in random case; now and then a letter that reads as zero
    function automatic logic [7:0] hex_char(input int v);
        if ($urandom_range(19) == 0) return 8'($urandom_range("Z", "G"));
        if (v < 10) return 8'("0" + v);
        return 8'(($urandom_range(1) ? "a" : "A") + v - 10);
    endfunction

    function automatic string hex_text(input int unsigned v, input int digits);
        string s;
        s = "";
        for (int i = digits - 1; i >= 0; i--)
            s = $sformatf("%s%c", s, hex_char((v >> (4 * i)) & 15));
        return s;
    endfunction

    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++) push_item(CMD_BYTE, s[i]);
        push_item(CMD_BYTE, line_end());
    endtask

    // Colour mode: 0 all black, 1 all white, otherwise random
    task automatic send_frame(input int unsigned delay, input int mode);
        string s;
        s = {"F", hex_text(delay, 4)};
        for (int i = 0; i < LEDS_DEF; i++)
            s = {s, hex_text(mode == 0 ? 0 : mode == 1 ? 24'hFFFFFF : $urandom, 6)};
        send_line(s);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) push_item(CMD_TICK, 8'($urandom));
    endtask

    function automatic int unsigned short_delay();
        return $urandom_range(9) == 0 ? $urandom_range(65535, 60000) : $urandom_range(4);
    endfunction

    // Random well-formed animation: start, frames, end, then ticks
    task automatic play_animation();
        int n;
        n = $urandom_range(5);
        send_line({"S", hex_text($urandom_range(9) == 0 ? $urandom_range(255) : n, 2)});
        repeat ($urandom_range(6)) send_frame(short_delay(), 2);
        send_line($urandom_range(3) == 0 ? {"E", hex_text($urandom, 3)} : "E");
        send_ticks($urandom_range(15));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(10, 1)) begin
            if ($urandom_range(3) == 0) push_item(2'($urandom), 8'($urandom));
            else if ($urandom_range(5) == 0) push_item(CMD_BYTE, line_end());
            else push_item(CMD_BYTE, 8'($urandom));
        end
    endtask

    initial begin
        calm          = 1'b0;
        sent          = 0;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.cmd     <= CMD_BYTE;
        in_ch.rx_byte <= 8'd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty bank, black frame, clamps, broken and odd lines
        send_ticks(2);
        send_line("E");
        push_item(CMD_BYTE, CH_CR);
        send_line("S02");
        send_frame(0, 1);
        send_frame(16'hFFFF, 0);
        send_line("S1");
        send_line("F12");
        send_line("X123");
        push_item(CMD_BYTE, CH_S);
        push_item(CMD_ERROR, 8'hFF);
        push_item(2'd3, 8'h00);
        send_line("Extra");
        send_ticks(3);
        repeat (70) push_item(CMD_BYTE, "A");
        push_item(CMD_BYTE, CH_LF);
        send_line("S99");

        // Random part with a calm stretch in the middle
        while (sent < 1100) begin
            int pick;
            pick = $urandom_range(99);
            calm = sent > 400 && sent < 650;
            if (pick < 60) play_animation();
            else if (pick < 75) send_ticks($urandom_range(10, 1));
            else if (pick < 85) repeat ($urandom_range(3, 1)) send_frame(short_delay(), 2);
            else if (pick < 93) send_noise();
            else begin
                push_item(CMD_BYTE, CH_F);
                push_item(CMD_BYTE, hex_char($urandom_range(15)));
                push_item(CMD_ERROR, 8'($urandom));
            end
        end
        calm = 1'b0;
        in_ch.valid <= 1'b0;

        // Drain, then allow for a late bank clear
        for (int n = 0; pending != 0 && n < 200000; n++) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #30000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
